/* rtl/wavelet_subband_extent_generator_core_assert.svh */
// Assertion macros used by the subband extent generator checker.
// Both macros expand to one labeled concurrent assertion reporting by $error.
`ifndef WAVELET_SUBBAND_EXTENT_GENERATOR_CORE_ASSERT_SVH
`define WAVELET_SUBBAND_EXTENT_GENERATOR_CORE_ASSERT_SVH

// Property checked on every rising edge outside reset.
`define WSEG_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define WSEG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/wseg_pkg.sv */
// Shared types and constants of the wavelet subband extent generator.
// No dependencies.
package wseg_pkg;

	localparam int SIZE_W = 16;
	localparam int NUM_AXES = 3;

	typedef logic [SIZE_W-1:0] dim_t;
	typedef logic [2:0] band_code_t;
	typedef logic [2:0] code_idx_t;

	// Band order within one level; entry 0 is the approximation band.
	localparam band_code_t BAND_CODE [8] = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7};
	localparam code_idx_t FIRST_DETAIL = 3'd1;
	localparam code_idx_t LAST_DETAIL = 3'd7;

	typedef enum logic [1:0] {
		LD_APPROX,
		LD_DETAIL,
		LD_BAD
	} load_kind_t;

	// Controller to datapath
	typedef struct packed {
		logic start;
		logic halve;
		logic pop;
		logic load;
		load_kind_t kind;
		band_code_t code;
		logic last;
	} wseg_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic req_bad;
		logic nonzero;
		band_code_t big_axes;
	} wseg_status_t;

endpackage

/* rtl/wseg_datapath.sv */
// Datapath: region sizes, halving stack and the result registers.
// Depends on wseg_pkg; driven by wseg_controller commands.
module wseg_datapath #(
	parameter int MAX_LEVELS = 8
) (
	input  logic                 clk,
	input  logic [1:0]           num_dims,
	input  wseg_pkg::dim_t       size_x,
	input  wseg_pkg::dim_t       size_y,
	input  wseg_pkg::dim_t       size_z,
	input  logic [3:0]           num_levels,
	input  wseg_pkg::wseg_cmd_t  cmd,
	output wseg_pkg::wseg_status_t status,
	output wseg_pkg::dim_t       offset_x,
	output wseg_pkg::dim_t       offset_y,
	output wseg_pkg::dim_t       offset_z,
	output wseg_pkg::dim_t       extent_x,
	output wseg_pkg::dim_t       extent_y,
	output wseg_pkg::dim_t       extent_z,
	output logic                 last,
	output logic                 bad_request
);
	import wseg_pkg::*;

	dim_t cur_q [NUM_AXES];
	dim_t stk_q [MAX_LEVELS][NUM_AXES];
	dim_t off_q [NUM_AXES];
	dim_t ext_q [NUM_AXES];
	logic last_q;
	logic bad_q;
	band_code_t big_q;
	dim_t band_off [NUM_AXES];
	dim_t band_ext [NUM_AXES];
	logic zero_size;

	// Check the request rules on the input ports, then form the band picked by
	// the current code from the top of stack and the low size
	always_comb begin
		zero_size = (size_x == '0) || (size_y == '0) || (size_z == '0);
		status.req_bad = (num_dims == 2'd0) || (num_dims < 2'd2 && size_y != 16'd1)
			|| (num_dims < 2'd3 && size_z != 16'd1) || zero_size
			|| (32'(num_levels) > MAX_LEVELS);
		status.nonzero = 1'b1;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (cmd.code[2-a]) begin
				band_off[a] = cur_q[a];
				band_ext[a] = stk_q[0][a] - cur_q[a];
			end else begin
				band_off[a] = '0;
				band_ext[a] = cur_q[a];
			end
			if (band_ext[a] == '0) status.nonzero = 1'b0;
		end
		status.big_axes = big_q;
	end

	// Capture, halve, push and pop the per-level sizes
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cur_q[0] <= size_x;
			cur_q[1] <= size_y;
			cur_q[2] <= size_z;
			big_q <= {size_x > 16'd1, size_y > 16'd1, size_z > 16'd1};
		end else if (cmd.halve) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				cur_q[a] <= (cur_q[a] >> 1) + dim_t'(cur_q[a][0]);
				stk_q[0][a] <= cur_q[a];
				for (int i = 1; i < MAX_LEVELS; i++) stk_q[i][a] <= stk_q[i-1][a];
			end
		end else if (cmd.pop) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				cur_q[a] <= stk_q[0][a];
				for (int i = 0; i < MAX_LEVELS - 1; i++) stk_q[i][a] <= stk_q[i+1][a];
			end
		end
	end

	// Load the result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			last_q <= cmd.last;
			unique case (cmd.kind)
				LD_APPROX: begin
					for (int a = 0; a < NUM_AXES; a++) begin
						off_q[a] <= '0;
						ext_q[a] <= cur_q[a];
					end
					bad_q <= 1'b0;
				end
				LD_DETAIL: begin
					for (int a = 0; a < NUM_AXES; a++) begin
						off_q[a] <= band_off[a];
						ext_q[a] <= band_ext[a];
					end
					bad_q <= 1'b0;
				end
				default: begin
					for (int a = 0; a < NUM_AXES; a++) begin
						off_q[a] <= '0;
						ext_q[a] <= '0;
					end
					bad_q <= 1'b1;
				end
			endcase
		end
	end

	assign offset_x = off_q[0];
	assign offset_y = off_q[1];
	assign offset_z = off_q[2];
	assign extent_x = ext_q[0];
	assign extent_y = ext_q[1];
	assign extent_z = ext_q[2];
	assign last = last_q;
	assign bad_request = bad_q;

endmodule

/* rtl/wseg_controller.sv */
// Controller: sequences halving, approximation band and detail bands per request, or one bad-request band.
// Depends on wseg_pkg; commands wseg_datapath and owns both handshakes.
module wseg_controller #(
	parameter int MAX_LEVELS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [3:0]             num_levels,
	output logic                   out_valid,
	input  logic                   out_stall,
	input  wseg_pkg::wseg_status_t status,
	output wseg_pkg::wseg_cmd_t    cmd
);
	import wseg_pkg::*;

	localparam int LW = $clog2(MAX_LEVELS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HALVE,
		ST_APPROX,
		ST_DETAIL,
		ST_BAD
	} state_t;

	state_t state_q;
	logic [LW-1:0] levels_q;
	logic [LW-1:0] lev_q;
	code_idx_t idx_q;
	logic out_valid_q;
	logic slot_free;
	logic approx_last;
	logic step;

	assign slot_free = !out_valid_q || !out_stall;
	assign approx_last = (levels_q == '0) || (status.big_axes == '0);
	assign step = !status.nonzero || slot_free;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Decode commands from the state
	always_comb begin
		cmd = '0;
		cmd.kind = LD_DETAIL;
		cmd.code = BAND_CODE[idx_q];
		unique case (state_q)
			ST_IDLE: cmd.start = in_valid;
			ST_HALVE: cmd.halve = (lev_q != levels_q);
			ST_APPROX: begin
				cmd.kind = LD_APPROX;
				cmd.load = slot_free;
				cmd.last = approx_last;
			end
			ST_DETAIL: begin
				cmd.load = status.nonzero && slot_free;
				cmd.last = (lev_q == '0) && (cmd.code == status.big_axes);
				cmd.pop = step && (idx_q == LAST_DETAIL) && (lev_q != '0);
			end
			ST_BAD: begin
				cmd.kind = LD_BAD;
				cmd.load = slot_free;
				cmd.last = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

	// Hold state, counters and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			levels_q <= '0;
			lev_q <= '0;
			idx_q <= FIRST_DETAIL;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (status.req_bad) begin
							state_q <= ST_BAD;
						end else begin
							levels_q <= LW'(num_levels);
							lev_q <= '0;
							state_q <= ST_HALVE;
						end
					end
				end
				ST_HALVE: begin
					if (lev_q == levels_q) state_q <= ST_APPROX;
					else lev_q <= lev_q + LW'(1);
				end
				ST_APPROX: begin
					if (slot_free) begin
						if (approx_last) begin
							state_q <= ST_IDLE;
						end else begin
							lev_q <= lev_q - LW'(1);
							idx_q <= FIRST_DETAIL;
							state_q <= ST_DETAIL;
						end
					end
				end
				ST_DETAIL: begin
					if (step) begin
						if (idx_q == LAST_DETAIL) begin
							idx_q <= FIRST_DETAIL;
							if (lev_q == '0) state_q <= ST_IDLE;
							else lev_q <= lev_q - LW'(1);
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				ST_BAD: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/wavelet_subband_extent_generator_core.sv */
// Wavelet subband extent generator, top level.
// Input channel in_valid/in_stall carries one request: num_dims, size_x/y/z and
// num_levels. Output channel out_valid/out_stall carries one subband per
// transaction: offset_x/y/z, extent_x/y/z, last and bad_request.
// A request is taken when in_valid is high and in_stall low; in_stall stays
// high until every band of that request has been loaded into the output register.
// The first band (coarsest approximation) is loaded once one halving step per
// level has been made after the accept.
// Throughput: one band code is examined per cycle, 7 per level, except that a code
// with a nonzero band waits while the output register is stalled.
// Zero-size bands are skipped silently. The final band of a request has last set.
// A rejected request yields one band with zero fields, last and bad_request set.
// The output register holds its band while out_stall is high; the controller
// waits and resumes with the next band code once the slot frees up.
// Reset (arst_n low) returns the controller to idle and drops out_valid.
// Depends on wseg_pkg, wseg_controller and wseg_datapath.
module wavelet_subband_extent_generator_core #(
	parameter int MAX_LEVELS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     num_dims,
	input  wseg_pkg::dim_t size_x,
	input  wseg_pkg::dim_t size_y,
	input  wseg_pkg::dim_t size_z,
	input  logic [3:0]     num_levels,
	output logic           out_valid,
	input  logic           out_stall,
	output wseg_pkg::dim_t offset_x,
	output wseg_pkg::dim_t offset_y,
	output wseg_pkg::dim_t offset_z,
	output wseg_pkg::dim_t extent_x,
	output wseg_pkg::dim_t extent_y,
	output wseg_pkg::dim_t extent_z,
	output logic           last,
	output logic           bad_request
);
	import wseg_pkg::*;

	wseg_cmd_t cmd;
	wseg_status_t status;

	wseg_controller #(.MAX_LEVELS(MAX_LEVELS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.num_levels (num_levels),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.cmd        (cmd)
	);

	wseg_datapath #(.MAX_LEVELS(MAX_LEVELS)) u_dp (
		.clk         (clk),
		.num_dims    (num_dims),
		.size_x      (size_x),
		.size_y      (size_y),
		.size_z      (size_z),
		.num_levels  (num_levels),
		.cmd         (cmd),
		.status      (status),
		.offset_x    (offset_x),
		.offset_y    (offset_y),
		.offset_z    (offset_z),
		.extent_x    (extent_x),
		.extent_y    (extent_y),
		.extent_z    (extent_z),
		.last        (last),
		.bad_request (bad_request)
	);

endmodule

/* rtl/wseg_checker.sv */
// Port-level checker for the subband extent generator, bound to the top level.
// Depends on wavelet_subband_extent_generator_core_assert.svh.
`include "wavelet_subband_extent_generator_core_assert.svh"

module wseg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  num_dims,
	input logic [15:0] size_x,
	input logic [15:0] size_y,
	input logic [15:0] size_z,
	input logic [3:0]  num_levels,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] offset_x,
	input logic [15:0] offset_y,
	input logic [15:0] offset_z,
	input logic [15:0] extent_x,
	input logic [15:0] extent_y,
	input logic [15:0] extent_z,
	input logic        last,
	input logic        bad_request
);

	// Hold a stalled result
	`WSEG_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(offset_x) && $stable(extent_x) && $stable(last), "stalled result changed")

	// A rejected request's band has zero extents and last set, closing the request
	`WSEG_ASSERT(a_bad_form, clk, arst_n, out_valid && bad_request |-> last && extent_x == 16'd0 && extent_y == 16'd0 && extent_z == 16'd0, "malformed bad result")

	// Good bands never have a zero extent
	`WSEG_ASSERT(a_good_nonzero, clk, arst_n, out_valid && !bad_request |-> extent_x != 16'd0 && extent_y != 16'd0 && extent_z != 16'd0, "zero-size band emitted")

	// A new request blocks the input for at least the next cycle
	`WSEG_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall |=> in_stall, "input not stalled after accept")

	// No result shows while reset is asserted
	`WSEG_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid, "out_valid during reset")

endmodule

bind wavelet_subband_extent_generator_core wseg_checker u_wseg_checker (.*);
